// ===== hdl/bcld_pkg.sv =====
// Shared constants and types for the button click and long-press detector.
package bcld_pkg;

  localparam int unsigned NumButtons = 3;
  localparam int unsigned TimeW      = 16;
  localparam int unsigned CountW     = 8;
  localparam int unsigned ElapsedW   = 8;

  localparam logic [CountW-1:0] DebounceCountReset = 8'd5;
  localparam logic [TimeW-1:0]  LongPressMsReset   = 16'd1000;
  localparam logic [TimeW-1:0]  TimeMax            = 16'hFFFF;
  localparam logic [CountW-1:0] CountMax           = 8'hFF;

  // configuration register indexes
  localparam logic CFG_DEBOUNCE_LEN  = 1'b0;
  localparam logic CFG_LONG_PRESS_MS = 1'b1;

  // event_button codes
  localparam logic [1:0] EV_BTN1  = 2'd0;
  localparam logic [1:0] EV_BTN2  = 2'd1;
  localparam logic [1:0] EV_BTN3  = 2'd2;
  localparam logic [1:0] EV_COMBO = 2'd3;

  // event_kind codes
  localparam logic EV_CLICK = 1'b0;
  localparam logic EV_LONG  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [1:0] button;
    logic       valid;
  } event_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [ElapsedW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {{(TimeW - ElapsedW + 1){1'b0}}, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

endpackage

// ===== hdl/button_click_longpress_detector_unit.sv =====
// Three-button debouncer with click, long-press and two-button combo detection.
//
// Takes one tick per transfer on s_axis and returns exactly one result per tick on m_axis.
// A tick sits in an input register, then its whole update (clear, debounce, hold timers,
// combo tracking, event priority) runs as one pass of logic into the result register, so
// one tick per clock is sustained while m_axis_tready stays high; the result register and
// the input register let a new tick enter while a result waits. Configuration writes
// on cfg_* are always ready and take effect at once; change them only while idle.
module button_click_longpress_detector_unit
  import bcld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // raw_pb1, raw_pb2, raw_pb3, elapsed[7:0], clear_events
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // pb1_pressed, pb2_pressed, pb3_pressed
  output logic [3:0]  m_axis_tuser,   // event_valid, event_button[1:0], event_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic [CountW-1:0] debounce_len;
  logic [TimeW-1:0]  long_press_ms;

  // input stage
  logic                in_vld;
  logic [2:0]          in_raw;
  logic [ElapsedW-1:0] in_elapsed;
  logic                in_clear;

  // output stage
  logic        out_vld;
  logic [2:0]  out_levels;
  event_t      out_event;

  // tick state
  logic [2:0]        level;
  logic [CountW-1:0] disagree [NumButtons];
  logic [TimeW-1:0]  held     [NumButtons];
  logic [2:0]        click_flag;
  logic [2:0]        long_done;
  logic [TimeW-1:0]  combo_time;
  logic              combo_click_flag;
  logic              combo_long_flag;
  logic              combo_long_done;
  logic [1:0]        combo_seen;

  logic [2:0]        level_next;
  logic [CountW-1:0] disagree_next [NumButtons];
  logic [TimeW-1:0]  held_next     [NumButtons];
  logic [2:0]        click_flag_next;
  logic [2:0]        long_done_next;
  logic [TimeW-1:0]  combo_time_next;
  logic              combo_click_flag_next;
  logic              combo_long_flag_next;
  logic              combo_long_done_next;
  logic [1:0]        combo_seen_next;
  event_t            event_next;

  logic advance;

  assign cfg_ready     = 1'b1;
  assign advance       = in_vld && (!out_vld || m_axis_tready);
  assign s_axis_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_len  <= DebounceCountReset;
      long_press_ms <= LongPressMsReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEBOUNCE_LEN:  debounce_len  <= cfg_data[CountW-1:0];
        CFG_LONG_PRESS_MS: long_press_ms <= cfg_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_raw     <= s_axis_tdata[2:0];
      in_elapsed <= s_axis_tdata[10:3];
      in_clear   <= s_axis_tdata[11];
    end
  end

  always_comb begin
    logic [CountW:0] c;
    level_next            = level;
    click_flag_next       = click_flag;
    long_done_next        = long_done;
    combo_time_next       = combo_time;
    combo_click_flag_next = combo_click_flag;
    combo_long_flag_next  = combo_long_flag;
    combo_long_done_next  = combo_long_done;
    combo_seen_next       = combo_seen;
    event_next            = '0;
    c                     = '0;

    if (in_clear) begin
      click_flag_next       = '0;
      long_done_next        = '1;
      combo_click_flag_next = 1'b0;
      combo_long_flag_next  = 1'b0;
      combo_long_done_next  = 1'b1;
    end

    // per-button debounce and hold timers
    for (int i = 0; i < NumButtons; i++) begin
      disagree_next[i] = disagree[i];
      held_next[i]     = held[i];
      if (in_raw[i] == level[i]) begin
        disagree_next[i] = '0;
      end else begin
        c = {1'b0, disagree[i]} + 1'b1;
        disagree_next[i] = c[CountW] ? CountMax : c[CountW-1:0];
        if (disagree_next[i] >= debounce_len) begin
          level_next[i]    = in_raw[i];
          disagree_next[i] = '0;
          if (in_raw[i]) begin
            long_done_next[i] = 1'b0;
          end else if (!long_done_next[i]) begin
            click_flag_next[i] = 1'b1;
          end
          held_next[i] = '0;
        end
      end
      if (level_next[i]) begin
        held_next[i] = sat_add(held_next[i], in_elapsed);
      end
    end

    // buttons 2 and 3 combo
    if (level_next[1]) combo_seen_next[0] = 1'b1;
    if (level_next[2]) combo_seen_next[1] = 1'b1;
    if (level_next[1] || level_next[2]) begin
      combo_time_next = sat_add(combo_time, in_elapsed);
    end
    if (level_next[1] && level_next[2]) begin
      if (combo_time_next >= long_press_ms && !combo_long_done_next) begin
        combo_long_done_next = 1'b1;
        combo_long_flag_next = 1'b1;
        click_flag_next[1]   = 1'b0;
        click_flag_next[2]   = 1'b0;
      end
    end
    if (!level_next[1] && !level_next[2]) begin
      if (combo_seen_next[0] && combo_seen_next[1] && combo_time_next != '0 &&
          combo_time_next < long_press_ms && !combo_long_done_next) begin
        combo_click_flag_next = 1'b1;
        click_flag_next[1]    = 1'b0;
        click_flag_next[2]    = 1'b0;
      end
      combo_time_next      = '0;
      combo_long_done_next = 1'b0;
      combo_seen_next      = '0;
    end

    // event priority; lower ones stay pending
    if (combo_click_flag_next) begin
      combo_click_flag_next = 1'b0;
      event_next = '{kind: EV_CLICK, button: EV_COMBO, valid: 1'b1};
    end else if (combo_long_flag_next) begin
      combo_long_flag_next = 1'b0;
      event_next = '{kind: EV_LONG, button: EV_COMBO, valid: 1'b1};
    end else if (click_flag_next[0]) begin
      click_flag_next[0] = 1'b0;
      event_next = '{kind: EV_CLICK, button: EV_BTN1, valid: 1'b1};
    end else if (level_next[2] && held_next[2] >= long_press_ms && !long_done_next[2]) begin
      long_done_next[2]  = 1'b1;
      click_flag_next[2] = 1'b0;
      event_next = '{kind: EV_LONG, button: EV_BTN3, valid: 1'b1};
    end else if (click_flag_next[2]) begin
      click_flag_next[2] = 1'b0;
      event_next = '{kind: EV_CLICK, button: EV_BTN3, valid: 1'b1};
    end else if (click_flag_next[1]) begin
      click_flag_next[1] = 1'b0;
      event_next = '{kind: EV_CLICK, button: EV_BTN2, valid: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level            <= '0;
      click_flag       <= '0;
      long_done        <= '0;
      combo_time       <= '0;
      combo_click_flag <= 1'b0;
      combo_long_flag  <= 1'b0;
      combo_long_done  <= 1'b0;
      combo_seen       <= '0;
      for (int i = 0; i < NumButtons; i++) begin
        disagree[i] <= '0;
        held[i]     <= '0;
      end
    end else if (advance) begin
      level            <= level_next;
      click_flag       <= click_flag_next;
      long_done        <= long_done_next;
      combo_time       <= combo_time_next;
      combo_click_flag <= combo_click_flag_next;
      combo_long_flag  <= combo_long_flag_next;
      combo_long_done  <= combo_long_done_next;
      combo_seen       <= combo_seen_next;
      for (int i = 0; i < NumButtons; i++) begin
        disagree[i] <= disagree_next[i];
        held[i]     <= held_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_levels <= level_next;
      out_event  <= event_next;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {5'b0, out_levels};
  assign m_axis_tuser  = out_event;

`ifndef SYNTH
  // a processed tick always lands in the result register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_vld)
    else $error("processed tick did not produce a result");

  // debounced levels only move when a tick is processed
  a_level_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(level))
    else $error("debounced level changed without a tick");

  // combo tracking is cleared once buttons 2 and 3 are both released
  a_combo_cleared: assert property (@(posedge clk) disable iff (rst)
    advance |=> (level[1] || level[2] ||
                 (combo_time == '0 && combo_seen == '0 && !combo_long_done)))
    else $error("combo tracking not cleared after release");

  // no event means zero button and kind fields
  a_idle_event_zero: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !out_event.valid) |-> (out_event.button == EV_BTN1 &&
                                       out_event.kind == EV_CLICK))
    else $error("event fields set without a valid event");
`endif

endmodule
